// File: rtl/erb_pkg.sv
// erb_pkg: shared constants, register indexes and queue entry type
// for the ellipse boundary rasterizer; no dependencies
`timescale 1ns / 1ps

package erb_pkg;

	// largest image dimension; larger settings saturate to it
	localparam int MAX_DIM = 4096;
	localparam int DIM_W   = $clog2(MAX_DIM + 1);

	// configuration register indexes
	localparam logic [2:0] REG_CENTER_X     = 3'd0;
	localparam logic [2:0] REG_CENTER_Y     = 3'd1;
	localparam logic [2:0] REG_SEMI_AXIS_A  = 3'd2;
	localparam logic [2:0] REG_SEMI_AXIS_B  = 3'd3;
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;

	// walk phases
	localparam logic [1:0] PH_DONE = 2'd0;
	localparam logic [1:0] PH_R1   = 2'd1;
	localparam logic [1:0] PH_R2   = 2'd2;

	localparam int QUEUE_DEPTH = 4;

	// one point handed from the walker to the emitter
	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic               has_pt;
		logic               last;
		logic               fin;
	} erb_entry_t;

endpackage

// File: rtl/erb_front.sv
// erb_front: midpoint walker; runs one iteration per word and pushes
// its mirrored points into the queue; depends on erb_pkg
`timescale 1ns / 1ps

module erb_front import erb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	input  logic signed [13:0] center_x,
	input  logic signed [13:0] center_y,
	input  logic [11:0]        semi_axis_a,
	input  logic [11:0]        semi_axis_b,
	output logic               push_valid,
	input  logic               push_ready,
	output erb_entry_t         push_entry
);

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_SQA  = 14'b00000000000010,
		S_SQB  = 14'b00000000000100,
		S_B2   = 14'b00000000001000,
		S_INIT = 14'b00000000010000,
		S_CHK  = 14'b00000000100000,
		S_TT   = 14'b00000001000000,
		S_P1   = 14'b00000010000000,
		S_UU   = 14'b00000100000000,
		S_P2   = 14'b00001000000000,
		S_P3   = 14'b00010000000000,
		S_D4   = 14'b00100000000000,
		S_STEP = 14'b01000000000000,
		S_EMIT = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic restart_q;

	// walk state
	logic [12:0]        walk_col_q, prior_col_q;
	logic signed [13:0] walk_row_q, prior_row_q;
	logic signed [39:0] stx_q, sty_q;
	logic signed [55:0] dec_q;
	logic [1:0]         phase_q;

	// squares and shared multiplier
	logic [23:0]        a2_q, b2_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_d, prod_q, acc_q;

	// latched emit description
	logic [12:0]        e_col_q, c_col_q;
	logic signed [13:0] e_row_q, c_row_q;
	logic               diag_q, pts_q, fin_q;
	logic [2:0]         idx_q;

	assign in_ready = (state_q == S_IDLE);

	// multiplier operand select
	logic [13:0]        t_val;
	logic signed [14:0] u_val;
	assign t_val = {walk_col_q, 1'b1};
	assign u_val = 15'(walk_row_q) - 15'sd1;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQA: begin
				mul_a = {20'd0, semi_axis_a};
				mul_b = {20'd0, semi_axis_a};
			end
			S_SQB: begin
				mul_a = {20'd0, semi_axis_b};
				mul_b = {20'd0, semi_axis_b};
			end
			S_B2: begin
				mul_a = {8'd0, a2_q};
				mul_b = {20'd0, semi_axis_b};
			end
			S_CHK: begin
				mul_a = {18'd0, t_val};
				mul_b = {18'd0, t_val};
			end
			S_TT: begin
				mul_a = {8'd0, b2_q};
				mul_b = prod_q[31:0];
			end
			S_P1: begin
				mul_a = 32'(u_val);
				mul_b = 32'(u_val);
			end
			S_UU: begin
				mul_a = {8'd0, a2_q};
				mul_b = prod_q[31:0];
			end
			S_P2: begin
				mul_a = {8'd0, a2_q};
				mul_b = {8'd0, b2_q};
			end
			default: ;
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// one iteration of either region
	logic signed [39:0] b2x2, a2x2;
	logic signed [55:0] b2w, a2w;
	logic signed [39:0] stx1, sty1, stx2, sty2;
	logic signed [55:0] dec1, dec2;
	logic [12:0]        col1, col2;
	logic signed [13:0] row1, row2;
	logic signed [13:0] dc;
	logic signed [14:0] dr;
	logic               diag;

	always_comb begin
		b2x2 = {15'd0, b2_q, 1'b0};
		a2x2 = {15'd0, a2_q, 1'b0};
		b2w  = {32'd0, b2_q};
		a2w  = {32'd0, a2_q};
		// region 1
		col1 = walk_col_q + 13'd1;
		stx1 = stx_q + b2x2;
		if (dec_q < 0) begin
			row1 = walk_row_q;
			sty1 = sty_q;
			dec1 = dec_q + 56'(stx1) + b2w;
		end else begin
			row1 = walk_row_q - 14'sd1;
			sty1 = sty_q - a2x2;
			dec1 = dec_q + 56'(stx1) - 56'(sty1) + b2w;
		end
		// region 2
		row2 = walk_row_q - 14'sd1;
		sty2 = sty_q - a2x2;
		if (dec_q > 0) begin
			col2 = walk_col_q;
			stx2 = stx_q;
			dec2 = dec_q + a2w - 56'(sty2);
		end else begin
			col2 = walk_col_q + 13'd1;
			stx2 = stx_q + b2x2;
			dec2 = dec_q + 56'(stx2) - 56'(sty2) + a2w;
		end
		dc   = {1'b0, walk_col_q} - {1'b0, prior_col_q};
		dr   = 15'(walk_row_q) - 15'(prior_row_q);
		diag = (dc == 14'sd1 || dc == -14'sd1) && (dr == 15'sd1 || dr == -15'sd1);
	end

	// queue push of the current point
	logic [12:0]        base_col;
	logic signed [13:0] base_row;
	logic               emit_last;

	always_comb begin
		base_col  = idx_q[2] ? c_col_q : e_col_q;
		base_row  = idx_q[2] ? c_row_q : e_row_q;
		emit_last = !pts_q || (idx_q == 3'd3 && !diag_q) || (idx_q == 3'd7);
		push_entry.px = idx_q[0] ? 16'(center_x) - {3'd0, base_col}
			: 16'(center_x) + {3'd0, base_col};
		push_entry.py = idx_q[1] ? 16'(center_y) - 16'(base_row)
			: 16'(center_y) + 16'(base_row);
		push_entry.has_pt = pts_q;
		push_entry.last   = emit_last;
		push_entry.fin    = fin_q;
	end

	assign push_valid = (state_q == S_EMIT);

	// region-2 start, truncated toward zero
	logic signed [63:0] acc_q3;
	assign acc_q3 = acc_q + 64'sd3;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			restart_q   <= 1'b0;
			walk_col_q  <= '0;
			walk_row_q  <= '0;
			prior_col_q <= '0;
			prior_row_q <= '0;
			stx_q       <= '0;
			sty_q       <= '0;
			dec_q       <= '0;
			phase_q     <= PH_DONE;
			idx_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						restart_q <= restart;
						state_q   <= S_SQA;
					end
				end
				S_SQA: state_q <= S_SQB;
				S_SQB: state_q <= S_B2;
				S_B2: state_q <= restart_q ? S_INIT : S_CHK;
				S_INIT: begin
					walk_col_q  <= '0;
					walk_row_q  <= {2'b00, semi_axis_b};
					prior_col_q <= '0;
					prior_row_q <= {2'b00, semi_axis_b};
					stx_q       <= '0;
					sty_q       <= {3'd0, prod_q[35:0], 1'b0};
					dec_q       <= {32'd0, b2_q} - {20'd0, prod_q[35:0]} + {34'd0, a2_q[23:2]};
					phase_q     <= PH_R1;
					state_q     <= S_CHK;
				end
				S_CHK: begin
					if (phase_q == PH_R1 && !(stx_q < sty_q))
						state_q <= S_TT;
					else
						state_q <= S_STEP;
				end
				S_TT: state_q <= S_P1;
				S_P1: begin
					acc_q   <= prod_q;
					state_q <= S_UU;
				end
				S_UU: state_q <= S_P2;
				S_P2: begin
					acc_q   <= acc_q + (prod_q <<< 2);
					state_q <= S_P3;
				end
				S_P3: begin
					acc_q   <= acc_q - (prod_q <<< 2);
					state_q <= S_D4;
				end
				S_D4: begin
					dec_q   <= (acc_q < 0) ? acc_q3[57:2] : acc_q[57:2];
					phase_q <= PH_R2;
					state_q <= S_STEP;
				end
				S_STEP: begin
					e_col_q <= walk_col_q;
					e_row_q <= walk_row_q;
					diag_q  <= diag;
					idx_q   <= '0;
					if (phase_q == PH_R1) begin
						c_col_q     <= prior_col_q;
						c_row_q     <= walk_row_q;
						pts_q       <= 1'b1;
						fin_q       <= 1'b0;
						prior_col_q <= walk_col_q;
						prior_row_q <= walk_row_q;
						walk_col_q  <= col1;
						walk_row_q  <= row1;
						stx_q       <= stx1;
						sty_q       <= sty1;
						dec_q       <= dec1;
					end else if (phase_q == PH_R2 && walk_row_q >= 0) begin
						c_col_q     <= walk_col_q;
						c_row_q     <= prior_row_q;
						pts_q       <= 1'b1;
						fin_q       <= (row2 < 0);
						prior_col_q <= walk_col_q;
						prior_row_q <= walk_row_q;
						walk_col_q  <= col2;
						walk_row_q  <= row2;
						stx_q       <= stx2;
						sty_q       <= sty2;
						dec_q       <= dec2;
						if (row2 < 0)
							phase_q <= PH_DONE;
					end else begin
						pts_q <= 1'b0;
						fin_q <= 1'b1;
						if (phase_q == PH_R2)
							phase_q <= PH_DONE;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (push_ready) begin
						if (emit_last)
							state_q <= S_IDLE;
						else
							idx_q <= idx_q + 3'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// multiplier result and squares
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (state_q == S_SQB)
			a2_q <= prod_q[23:0];
		if (state_q == S_B2)
			b2_q <= prod_q[23:0];
	end

endmodule

// File: rtl/erb_queue.sv
// erb_queue: short point queue between walker and emitter
// depends on erb_pkg
`timescale 1ns / 1ps

module erb_queue import erb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  erb_entry_t push_entry,
	output logic       pop_valid,
	input  logic       pop_ready,
	output erb_entry_t pop_entry
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	erb_entry_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [PW:0]       cnt_q;
	logic              do_push, do_pop;

	assign push_ready = (cnt_q != (PW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_entry  = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_entry;
	end

endmodule

// File: rtl/erb_back.sv
// erb_back: clips each point, finds its inner neighbour and forms
// linear offsets into the output register; depends on erb_pkg
`timescale 1ns / 1ps

module erb_back import erb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  erb_entry_t         pop_entry,
	input  logic signed [13:0] center_x,
	input  logic signed [13:0] center_y,
	input  logic [12:0]        image_width,
	input  logic [12:0]        image_height,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [79:0]        m_tdata,
	output logic               m_tlast,
	output logic               m_tuser
);

	logic [DIM_W-1:0] wd, ht;
	assign wd = (image_width > 13'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(image_width);
	assign ht = (image_height > 13'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(image_height);

	// clip test and inner neighbour
	logic signed [16:0] px, py, dx, dy, xi, yi;
	logic               out_in, in_in;

	always_comb begin
		px = 17'(pop_entry.px);
		py = 17'(pop_entry.py);
		dx = 17'(center_x) - px;
		dy = 17'(center_y) - py;
		xi = px + ((dx > 0) ? 17'sd1 : (dx < 0) ? -17'sd1 : 17'sd0);
		yi = py + ((dy > 0) ? 17'sd1 : (dy < 0) ? -17'sd1 : 17'sd0);
		out_in = pop_entry.has_pt && px >= 0 && px < 17'(wd) && py >= 0 && py < 17'(ht);
		in_in  = out_in && xi >= 0 && xi < 17'(wd) && yi >= 0 && yi < 17'(ht);
	end

	logic        vld_s1, ov_s1, iv_s1, last_s1, fin_s1;
	logic [11:0] ox_s1, oy_s1, ix_s1, iy_s1;
	logic        s1_ready;
	logic        out_vld_q;

	assign s1_ready  = !out_vld_q || m_tready;
	assign pop_ready = !vld_s1 || s1_ready;

	// stage 1: clipped coordinates, zero when outside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (pop_ready)
			vld_s1 <= pop_valid;
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			ov_s1   <= out_in;
			iv_s1   <= in_in;
			ox_s1   <= out_in ? px[11:0] : '0;
			oy_s1   <= out_in ? py[11:0] : '0;
			ix_s1   <= in_in ? xi[11:0] : '0;
			iy_s1   <= in_in ? yi[11:0] : '0;
			last_s1 <= pop_entry.last;
			fin_s1  <= pop_entry.fin;
		end
	end

	// stage 2: offsets into the output register
	logic [24:0] ooff, ioff;
	assign ooff = 25'(oy_s1) * 25'(wd) + 25'(ox_s1);
	assign ioff = 25'(iy_s1) * 25'(wd) + 25'(ix_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (s1_ready)
			out_vld_q <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_ready && vld_s1) begin
			m_tdata <= {6'd0, iv_s1, ix_s1, ioff[23:0], ov_s1, ox_s1, ooff[23:0]};
			m_tlast <= last_s1;
			m_tuser <= fin_s1;
		end
	end

	assign m_tvalid = out_vld_q;

endmodule

// File: rtl/ellipse_boundary_rasterizer.sv
// ellipse_boundary_rasterizer: top level with the register file
// depends on erb_pkg, erb_front, erb_queue, erb_back
`timescale 1ns / 1ps

// Midpoint ellipse boundary rasterizer.
// Slave stream: each word is one step; tdata bit 0 = restart starts a new
// ellipse from the top, 0 advances one iteration of the walk.
// Master stream: one word per emitted point; tlast marks the last word of a
// step, tuser says the ellipse is fully traversed. A step gives four words,
// eight when it moved diagonally, or one all-zero word when nothing is left.
// APB port: centre, semi-axes and image size at byte addresses 0..20;
// write only while no step is in flight.
// Sequencing: a step runs the walker's square, check and step states, then
// pushes its words into the queue one by one; a restart adds an init state and
// the region change a longer sequence on the walker's shared 32x32 multiplier.
// Each word passes the queue and then the emitter's stages before it appears.
// A queue and a two-stage emitter hold results while m_tready is low; the
// walker stalls only when the queue is full and takes no new step until the
// current one is pushed.
// Reset returns the registers to centre 128,128, axes 64, image 256x256 and
// leaves the walk finished until a restart.

module ellipse_boundary_rasterizer import erb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	// [23:0] outer_offset, [35:24] outer_col, [36] outer_valid,
	// [60:37] inner_offset, [72:61] inner_col, [73] inner_valid
	output logic [79:0] m_tdata,
	output logic        m_tlast,
	output logic        m_tuser    // [0] finished
);

	logic signed [13:0] center_x_q, center_y_q;
	logic [11:0]        axis_a_q, axis_b_q;
	logic [12:0]        width_q, height_q;
	logic [2:0]         reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= 14'sd128;
			center_y_q <= 14'sd128;
			axis_a_q   <= 12'd64;
			axis_b_q   <= 12'd64;
			width_q    <= 13'd256;
			height_q   <= 13'd256;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_CENTER_X:     center_x_q <= pwdata[13:0];
				REG_CENTER_Y:     center_y_q <= pwdata[13:0];
				REG_SEMI_AXIS_A:  axis_a_q   <= pwdata[11:0];
				REG_SEMI_AXIS_B:  axis_b_q   <= pwdata[11:0];
				REG_IMAGE_WIDTH:  width_q    <= pwdata[12:0];
				REG_IMAGE_HEIGHT: height_q   <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_CENTER_X:     prdata = 32'(center_x_q);
			REG_CENTER_Y:     prdata = 32'(center_y_q);
			REG_SEMI_AXIS_A:  prdata = {20'd0, axis_a_q};
			REG_SEMI_AXIS_B:  prdata = {20'd0, axis_b_q};
			REG_IMAGE_WIDTH:  prdata = {19'd0, width_q};
			REG_IMAGE_HEIGHT: prdata = {19'd0, height_q};
			default:          prdata = '0;
		endcase
	end

	erb_entry_t push_entry, pop_entry;
	logic       push_valid, push_ready, pop_valid, pop_ready;

	erb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.restart     (s_tdata[0]),
		.center_x    (center_x_q),
		.center_y    (center_y_q),
		.semi_axis_a (axis_a_q),
		.semi_axis_b (axis_b_q),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_entry  (push_entry)
	);

	erb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	erb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_entry    (pop_entry),
		.center_x     (center_x_q),
		.center_y     (center_y_q),
		.image_width  (width_q),
		.image_height (height_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser)
	);

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for the ellipse boundary rasterizer
// depends on erb_pkg and ellipse_boundary_rasterizer; predicts every word in-bench
`timescale 1ns / 1ps

module tb_top;
	import erb_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct packed {
		logic [23:0] outer_offset;
		logic [11:0] outer_col;
		logic        outer_valid;
		logic [23:0] inner_offset;
		logic [11:0] inner_col;
		logic        inner_valid;
		logic        last_of_step;
		logic        finished;
	} point_word_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [0] restart
	logic        m_tvalid;
	logic        m_tready;
	// [23:0] outer_offset, [35:24] outer_col, [36] outer_valid,
	// [60:37] inner_offset, [72:61] inner_col, [73] inner_valid
	logic [79:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;   // [0] finished

	// bench copy of the registers
	longint cfg_cx, cfg_cy, cfg_a, cfg_b, cfg_w, cfg_h;

	// bench copy of the walk state
	longint walk_col, walk_row, prior_col, prior_row;
	longint term_x, term_y, decision;
	logic [1:0] walk_phase;

	point_word_t expected_words[$];
	int step_word_count;
	point_word_t step_words[8];

	int  mismatches;
	int  failures;
	int  idle_cycles;
	int  items_sent;
	bit  quiet;
	int  stall_left;

	ellipse_boundary_rasterizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// two's complement wrap of v to w bits
	function automatic longint wrap_to(longint v, int w);
		longint m;
		longint u;
		m = (longint'(1) << w) - 1;
		u = v & m;
		if (u[w-1])
			return u - (longint'(1) << w);
		return u;
	endfunction

	function automatic longint sign_of(longint v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	function automatic longint abs_of(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint dim_w();
		return (cfg_w > MAX_DIM) ? MAX_DIM : cfg_w;
	endfunction

	function automatic longint dim_h();
		return (cfg_h > MAX_DIM) ? MAX_DIM : cfg_h;
	endfunction

	function automatic bit in_image(longint px, longint py);
		return px >= 0 && px < dim_w() && py >= 0 && py < dim_h();
	endfunction

	// one boundary point with its inner neighbour, clipped to the image
	task automatic add_point(longint px, longint py);
		point_word_t pw;
		longint xi, yi;
		if (step_word_count >= 8)
			return;
		pw = '{default: '0};
		if (in_image(px, py)) begin
			pw.outer_offset = 24'(py * dim_w() + px);
			pw.outer_col    = 12'(px);
			pw.outer_valid  = 1'b1;
			xi = px + sign_of(cfg_cx - px);
			yi = py + sign_of(cfg_cy - py);
			if (in_image(xi, yi)) begin
				pw.inner_offset = 24'(yi * dim_w() + xi);
				pw.inner_col    = 12'(xi);
				pw.inner_valid  = 1'b1;
			end
		end
		step_words[step_word_count] = pw;
		step_word_count++;
	endtask

	task automatic add_mirrors(longint x, longint y);
		add_point(cfg_cx + x, cfg_cy + y);
		add_point(cfg_cx - x, cfg_cy + y);
		add_point(cfg_cx + x, cfg_cy - y);
		add_point(cfg_cx - x, cfg_cy - y);
	endtask

	// one midpoint iteration; queues the words it produces
	task automatic predict_step(bit restart);
		longint a2, b2, t, u, d4, x, y;
		bit diag;
		a2 = cfg_a * cfg_a;
		b2 = cfg_b * cfg_b;
		step_word_count = 0;
		if (restart) begin
			walk_col   = 0;
			walk_row   = cfg_b;
			prior_col  = 0;
			prior_row  = cfg_b;
			term_x     = 0;
			term_y     = wrap_to(2 * a2 * cfg_b, 40);
			decision   = wrap_to(b2 - a2 * cfg_b + a2 / 4, 56);
			walk_phase = PH_R1;
		end
		// switch to region 2 once the slope passes -1
		if (walk_phase == PH_R1 && !(term_x < term_y)) begin
			t = 2 * walk_col + 1;
			u = walk_row - 1;
			d4 = b2 * t * t + 4 * a2 * u * u - 4 * a2 * b2;
			decision = wrap_to(d4 / 4, 56);
			walk_phase = PH_R2;
		end
		x = walk_col;
		y = walk_row;
		if (walk_phase == PH_R1) begin
			diag = abs_of(x - prior_col) == 1 && abs_of(y - prior_row) == 1;
			add_mirrors(x, y);
			if (diag)
				add_mirrors(prior_col, y);
			prior_col = walk_col;
			prior_row = walk_row;
			walk_col = (walk_col + 1) & 'h1FFF;
			term_x = wrap_to(term_x + 2 * b2, 40);
			if (decision < 0) begin
				decision = wrap_to(decision + term_x + b2, 56);
			end else begin
				walk_row = wrap_to(walk_row - 1, 14);
				term_y = wrap_to(term_y - 2 * a2, 40);
				decision = wrap_to(decision + term_x - term_y + b2, 56);
			end
		end else if (walk_phase == PH_R2) begin
			if (walk_row >= 0) begin
				diag = abs_of(x - prior_col) == 1 && abs_of(y - prior_row) == 1;
				add_mirrors(x, y);
				if (diag)
					add_mirrors(x, prior_row);
				prior_col = walk_col;
				prior_row = walk_row;
				walk_row = wrap_to(walk_row - 1, 14);
				term_y = wrap_to(term_y - 2 * a2, 40);
				if (decision > 0) begin
					decision = wrap_to(decision + a2 - term_y, 56);
				end else begin
					walk_col = (walk_col + 1) & 'h1FFF;
					term_x = wrap_to(term_x + 2 * b2, 40);
					decision = wrap_to(decision + term_x - term_y + a2, 56);
				end
			end
			if (walk_row < 0)
				walk_phase = PH_DONE;
		end
		// nothing drawn: a single empty word
		if (step_word_count == 0) begin
			step_words[0] = '{default: '0};
			step_word_count = 1;
		end
		for (int k = 0; k < step_word_count; k++) begin
			step_words[k].last_of_step = (k == step_word_count - 1);
			step_words[k].finished = !(walk_phase == PH_R1 || walk_phase == PH_R2);
			expected_words.push_back(step_words[k]);
		end
	endtask

	// register write: setup phase, then access phase, then idle
	task automatic write_reg(logic [2:0] idx, longint value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_CENTER_X:     cfg_cx = wrap_to(value & 'h3FFF, 14);
			REG_CENTER_Y:     cfg_cy = wrap_to(value & 'h3FFF, 14);
			REG_SEMI_AXIS_A:  cfg_a  = value & 'hFFF;
			REG_SEMI_AXIS_B:  cfg_b  = value & 'hFFF;
			REG_IMAGE_WIDTH:  cfg_w  = value & 'h1FFF;
			REG_IMAGE_HEIGHT: cfg_h  = value & 'h1FFF;
			default: ;
		endcase
	endtask

	task automatic set_ellipse(longint cx, longint cy, longint a, longint b,
			longint w, longint h);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_SEMI_AXIS_A, a);
		write_reg(REG_SEMI_AXIS_B, b);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	// send one step word; valid stays high when no gap follows
	task automatic send_step(bit restart);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, restart};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_step(restart);
		items_sent++;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait until every expected word has come
	task automatic wait_drained();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// restart and walk until the ellipse is finished, capped
	task automatic walk_ellipse(int max_steps);
		int n;
		send_step(1'b1);
		n = 1;
		while (walk_phase != PH_DONE && n < max_steps) begin
			send_step(1'b0);
			n++;
		end
	endtask

	task automatic test_default_walk();
		// step while finished after reset gives an empty word
		send_step(1'b0);
		walk_ellipse(8);
		wait_drained();
	endtask

	task automatic test_small_ellipses();
		set_ellipse(5, 4, 3, 2, 10, 8);
		walk_ellipse(40);
		// steps after the end are idle steps
		send_step(1'b0);
		send_step(1'b0);
		wait_drained();
		set_ellipse(6, 6, 5, 5, 12, 12);
		walk_ellipse(40);
		wait_drained();
	endtask

	task automatic test_degenerate_axes();
		set_ellipse(3, 3, 0, 0, 8, 8);
		walk_ellipse(10);
		wait_drained();
		write_reg(REG_SEMI_AXIS_B, 4);
		walk_ellipse(20);
		wait_drained();
		write_reg(REG_SEMI_AXIS_A, 4);
		write_reg(REG_SEMI_AXIS_B, 0);
		walk_ellipse(20);
		wait_drained();
	endtask

	task automatic test_clipping_extremes();
		// centre far outside the image
		set_ellipse(-4096, 8191, 2, 2, 1, 1);
		walk_ellipse(10);
		wait_drained();
		// zero size clips everything
		set_ellipse(1, 1, 2, 1, 0, 0);
		walk_ellipse(10);
		wait_drained();
		// oversized image saturates, largest axes, short walk
		set_ellipse(4095, 4095, 4095, 4095, 8191, 8191);
		walk_ellipse(4);
		wait_drained();
		set_ellipse(0, 0, 4095, 1, 4096, 1);
		walk_ellipse(4);
		wait_drained();
		// axes changed in the middle of a walk
		set_ellipse(8, 8, 6, 4, 16, 16);
		send_step(1'b1);
		send_step(1'b0);
		wait_drained();
		write_reg(REG_SEMI_AXIS_A, 2);
		repeat (3) send_step(1'b0);
		send_step(1'b0);
		wait_drained();
	endtask

	task automatic test_random_walks();
		int target;
		int steps;
		longint w, h;
		target = items_sent + 105;
		while (items_sent < target) begin
			if (target - items_sent < 30)
				quiet = 1'b1;
			wait_drained();
			if ($urandom_range(0, 7) == 0) begin
				set_ellipse($urandom_range(0, 16383), $urandom_range(0, 16383),
					$urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 8191), $urandom_range(0, 8191));
				steps = $urandom_range(1, 5);
			end else begin
				w = $urandom_range(1, 40);
				h = $urandom_range(1, 40);
				set_ellipse(longint'($urandom_range(0, 50)) - 5,
					longint'($urandom_range(0, 50)) - 5,
					$urandom_range(0, 12), $urandom_range(0, 12), w, h);
				steps = 60;
			end
			walk_ellipse(steps);
			// noise: stray steps and an occasional early restart
			repeat ($urandom_range(0, 2))
				send_step($urandom_range(0, 3) == 0);
		end
		wait_drained();
	endtask

	// result check against the oldest expectation
	always @(posedge clk) begin
		point_word_t want;
		point_word_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.outer_offset = m_tdata[23:0];
			got.outer_col    = m_tdata[35:24];
			got.outer_valid  = m_tdata[36];
			got.inner_offset = m_tdata[60:37];
			got.inner_col    = m_tdata[72:61];
			got.inner_valid  = m_tdata[73];
			got.last_of_step = m_tlast;
			got.finished     = m_tuser;
			if (expected_words.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: data=%h last=%b user=%b",
						m_tdata, m_tlast, m_tuser);
			end else begin
				want = expected_words.pop_front();
				if (got != want) begin
					failures++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp out=%h/%h/%b in=%h/%h/%b last=%b fin=%b, act out=%h/%h/%b in=%h/%h/%b last=%b fin=%b",
							want.outer_offset, want.outer_col, want.outer_valid,
							want.inner_offset, want.inner_col, want.inner_valid,
							want.last_of_step, want.finished,
							got.outer_offset, got.outer_col, got.outer_valid,
							got.inner_offset, got.inner_col, got.inner_valid,
							got.last_of_step, got.finished);
				end
			end
		end
	end

	// receiver stalls in random bursts
	always @(posedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		stall_left = 0;
		quiet = 1'b0;
		mismatches = 0;
		failures = 0;
		idle_cycles = 0;
		items_sent = 0;
		cfg_cx = 128;
		cfg_cy = 128;
		cfg_a = 64;
		cfg_b = 64;
		cfg_w = 256;
		cfg_h = 256;
		walk_col = 0;
		walk_row = 0;
		prior_col = 0;
		prior_row = 0;
		term_x = 0;
		term_y = 0;
		decision = 0;
		walk_phase = PH_DONE;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_walk();
		test_small_ellipses();
		test_degenerate_axes();
		test_clipping_extremes();
		test_random_walks();
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
rtl/erb_pkg.sv
rtl/erb_front.sv
rtl/erb_queue.sv
rtl/erb_back.sv
rtl/ellipse_boundary_rasterizer.sv
tb/tb_top.sv
